// ----- rtl/ursc_pkg.sv -----
// ursc_pkg: shared types and constants of the ultrasonic ranging scanner
// no dependencies; imported by every rtl module of the block

package ursc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SENSOR_COUNT   = 3'd0;
  localparam logic [2:0] REG_TRIGGER_TICKS  = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd2;
  localparam logic [2:0] REG_GAP_TICKS      = 3'd3;
  localparam logic [2:0] REG_DISTANCE_SCALE = 3'd4;

  // configuration reset values
  localparam logic [3:0]  RST_SENSOR_COUNT   = 4'd0;
  localparam logic [15:0] RST_TRIGGER_TICKS  = 16'd10;
  localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd38000;
  localparam logic [15:0] RST_GAP_TICKS      = 16'd10000;
  // 0.5 * 343.5 m/s at a 1 MHz tick, in mm per tick, 16.16
  localparam logic [23:0] RST_DISTANCE_SCALE = 24'd11256;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  typedef struct packed {
    logic [3:0]  sensor_count;
    logic [15:0] trigger_ticks;
    logic [15:0] timeout_ticks;
    logic [15:0] gap_ticks;
    logic [23:0] distance_scale;
  } cfg_t;

  // per-item record handed from the sequencer to the scaling stage
  typedef struct packed {
    logic [7:0] trigger_lines;
    logic       report_valid;
    logic [2:0] report_sensor;
    logic       timed_out;
    logic       measured;
  } stage_rec_t;

endpackage

// ----- rtl/ursc_if.sv -----
// ursc_if: valid/ready channel interfaces for echo samples and reports
// depends on nothing; used by the top level and its environment

interface ursc_echo_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_lines;

  modport source (output valid, output echo_lines, input ready);
  modport sink   (input valid, input echo_lines, output ready);
endinterface

interface ursc_report_if;
  logic        valid;
  logic        ready;
  logic [7:0]  trigger_lines;
  logic        report_valid;
  logic [2:0]  report_sensor;
  logic [15:0] distance_mm;
  logic        timed_out;

  modport source (output valid, output trigger_lines, output report_valid,
                  output report_sensor, output distance_mm, output timed_out,
                  input ready);
  modport sink   (input valid, input trigger_lines, input report_valid,
                  input report_sensor, input distance_mm, input timed_out,
                  output ready);
endinterface

// ----- rtl/ursc_ctrl.sv -----
// ursc_ctrl: scan sequencer (gap, trigger, wait for rise, echo high) and stage register
// depends on ursc_pkg

module ursc_ctrl import ursc_pkg::*; #(
  parameter int SENSORS     = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             echo_lines,
  output logic                   rec_valid,
  input  logic                   rec_ready,
  output stage_rec_t             rec,
  output logic [COUNT_WIDTH-1:0] rec_count
);

  localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    PH_GAP       = 4'b0001,
    PH_TRIGGER   = 4'b0010,
    PH_WAIT_RISE = 4'b0100,
    PH_ECHO_HIGH = 4'b1000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [IDX_W-1:0]       sensor_index, sensor_index_next, idx_wrap;
  logic [COUNT_WIDTH-1:0] phase_counter, phase_counter_next, pc_inc;
  logic [COUNT_WIDTH-1:0] echo_counter, echo_counter_next, ec_inc;
  logic [3:0]             count_lim;
  logic                   echo;
  logic                   accept;
  logic                   rpt, tout, meas;
  logic [7:0]             trig;

  assign accept   = in_valid && in_ready;
  assign in_ready = !rec_valid || rec_ready;

  // active sensor count, clipped to the number of sensors built in
  assign count_lim = (32'(cfg.sensor_count) > SENSORS) ? 4'(SENSORS) : cfg.sensor_count;

  // saturating increments
  assign pc_inc = (phase_counter == CNT_MAX) ? phase_counter
                : phase_counter + COUNT_WIDTH'(1);
  assign ec_inc = (echo_counter == CNT_MAX) ? echo_counter
                : echo_counter + COUNT_WIDTH'(1);

  // next sensor in round-robin order
  assign idx_wrap = ((5'(sensor_index) + 5'd1) >= 5'(count_lim)) ? '0
                  : sensor_index + IDX_W'(1);

  // echo level of the selected sensor; sensors past eight read low
  always_comb begin
    echo = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (32'(sensor_index) == i) echo = echo_lines[i];
    end
  end

  // phase sequencer
  always_comb begin
    phase_next         = phase;
    sensor_index_next  = sensor_index;
    phase_counter_next = phase_counter;
    echo_counter_next  = echo_counter;
    rpt  = 1'b0;
    tout = 1'b0;
    meas = 1'b0;
    if (count_lim == 4'd0) begin
      phase_next         = PH_GAP;
      phase_counter_next = '0;
      echo_counter_next  = '0;
    end else begin
      unique case (phase)
        PH_GAP: begin
          if (CMP_W'(phase_counter) >= CMP_W'(cfg.gap_ticks)) begin
            if (5'(sensor_index) >= 5'(count_lim)) sensor_index_next = '0;
            phase_next         = PH_TRIGGER;
            phase_counter_next = '0;
            echo_counter_next  = '0;
          end else begin
            phase_counter_next = pc_inc;
          end
        end
        PH_TRIGGER: begin
          phase_counter_next = pc_inc;
          if (CMP_W'(pc_inc) >= CMP_W'(cfg.trigger_ticks)) begin
            phase_next         = PH_WAIT_RISE;
            phase_counter_next = '0;
          end
        end
        PH_WAIT_RISE: begin
          if (echo) begin
            phase_next         = PH_ECHO_HIGH;
            echo_counter_next  = COUNT_WIDTH'(1);
            phase_counter_next = '0;
          end else begin
            phase_counter_next = pc_inc;
            if (CMP_W'(pc_inc) >= CMP_W'(cfg.timeout_ticks)) begin
              rpt  = 1'b1;
              tout = 1'b1;
            end
          end
        end
        PH_ECHO_HIGH: begin
          if (echo) begin
            echo_counter_next = ec_inc;
            if (CMP_W'(ec_inc) >= CMP_W'(cfg.timeout_ticks)) begin
              rpt  = 1'b1;
              tout = 1'b1;
            end
          end else begin
            rpt  = 1'b1;
            meas = 1'b1;
          end
        end
        default: begin
          phase_next = PH_GAP;
        end
      endcase
      // measurement finished: back to the gap on the next sensor
      if (rpt) begin
        sensor_index_next  = idx_wrap;
        phase_next         = PH_GAP;
        phase_counter_next = '0;
        echo_counter_next  = '0;
      end
    end
  end

  // trigger drive follows the state after this tick
  always_comb begin
    trig = '0;
    for (int i = 0; i < 8; i++) begin
      trig[i] = (phase_next == PH_TRIGGER) && (32'(sensor_index_next) == i);
    end
  end

  // sequencer state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_GAP;
      sensor_index  <= '0;
      phase_counter <= '0;
      echo_counter  <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      sensor_index  <= sensor_index_next;
      phase_counter <= phase_counter_next;
      echo_counter  <= echo_counter_next;
    end
  end

  // stage register toward the scaling stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (accept) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec.trigger_lines <= trig;
      rec.report_valid  <= rpt;
      rec.report_sensor <= rpt ? 3'(sensor_index) : 3'd0;
      rec.timed_out     <= tout;
      rec.measured      <= meas;
      rec_count         <= echo_counter;
    end
  end

`ifndef SYNTHESIS
  a_idle_gap: assert property (@(posedge clk) disable iff (rst)
    accept && count_lim == 4'd0 |=> phase == PH_GAP && phase_counter == '0)
    else $error("idle scan left the gap phase");

  a_report_to_gap: assert property (@(posedge clk) disable iff (rst)
    accept && rpt |=> phase == PH_GAP && echo_counter == '0)
    else $error("report not followed by a gap");

  a_trig_onehot: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> $onehot0(rec.trigger_lines))
    else $error("more than one trigger line driven");

  a_timeout_kind: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.timed_out |-> rec.report_valid && !rec.measured)
    else $error("timeout flagged on a non-report or a measurement");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec_count) && $stable(rec))
    else $error("stalled stage record changed");
`endif

endmodule

// ----- rtl/ursc_scale.sv -----
// ursc_scale: tick count to millimetre conversion with saturation, output register
// depends on ursc_pkg and ursc_if

module ursc_scale import ursc_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [23:0]            distance_scale,
  input  logic                   rec_valid,
  output logic                   rec_ready,
  input  stage_rec_t             rec,
  input  logic [COUNT_WIDTH-1:0] rec_count,
  ursc_report_if.source          report
);

  localparam int PROD_W = COUNT_WIDTH + 24;

  logic [PROD_W-1:0] product;
  logic [15:0]       range_mm;
  logic              take;

  assign rec_ready = !report.valid || report.ready;
  assign take      = rec_valid && rec_ready;

  // floor(count * scale / 65536), clipped to 16 bits
  assign product = PROD_W'(rec_count) * PROD_W'(distance_scale);
  always_comb begin
    if (!rec.measured) begin
      range_mm = 16'd0;
    end else if ((product >> 32) != '0) begin
      range_mm = 16'hFFFF;
    end else begin
      range_mm = product[31:16];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (take) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      report.trigger_lines <= rec.trigger_lines;
      report.report_valid  <= rec.report_valid;
      report.report_sensor <= rec.report_sensor;
      report.distance_mm   <= range_mm;
      report.timed_out     <= rec.timed_out;
    end
  end

endmodule

// ----- rtl/ultrasonic_ranging_scanner.sv -----
// Round-robin echo ranging scanner for up to eight ultrasonic sensors. Each item on
// echo_in is one timing tick of sampled echo levels and yields exactly one item on
// report_out holding the trigger drive for that tick and, when a measurement ends,
// the sensor index, the distance in mm (count times a 16.16 scale, saturated) or a
// timeout flag. One item is taken every clock while report_out does not stall; the
// sequencer stage registers an item at the edge that accepts it, and the multiplier
// stage that converts the echo count registers its report from that stage record.
// A stalled report_out holds echo_in back once both stages are full.
// Registers are written through cfg_we/cfg_index/cfg_data.
// depends on ursc_pkg, ursc_if, ursc_ctrl and ursc_scale

module ultrasonic_ranging_scanner import ursc_pkg::*; #(
  parameter int SENSORS     = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ursc_echo_if.sink             echo_in,
  ursc_report_if.source         report_out
);

  cfg_t                   cfg;
  logic                   rec_valid;
  logic                   rec_ready;
  stage_rec_t             rec;
  logic [COUNT_WIDTH-1:0] rec_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_count   <= RST_SENSOR_COUNT;
      cfg.trigger_ticks  <= RST_TRIGGER_TICKS;
      cfg.timeout_ticks  <= RST_TIMEOUT_TICKS;
      cfg.gap_ticks      <= RST_GAP_TICKS;
      cfg.distance_scale <= RST_DISTANCE_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSOR_COUNT:   cfg.sensor_count   <= cfg_data[3:0];
        REG_TRIGGER_TICKS:  cfg.trigger_ticks  <= cfg_data[15:0];
        REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= cfg_data[15:0];
        REG_GAP_TICKS:      cfg.gap_ticks      <= cfg_data[15:0];
        REG_DISTANCE_SCALE: cfg.distance_scale <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  ursc_ctrl #(
    .SENSORS     (SENSORS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (echo_in.valid),
    .in_ready   (echo_in.ready),
    .echo_lines (echo_in.echo_lines),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec),
    .rec_count  (rec_count)
  );

  // distance conversion and result register
  ursc_scale #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scale (
    .clk            (clk),
    .rst            (rst),
    .distance_scale (cfg.distance_scale),
    .rec_valid      (rec_valid),
    .rec_ready      (rec_ready),
    .rec            (rec),
    .rec_count      (rec_count),
    .report         (report_out)
  );

endmodule
